// ===== src/bcd_pkg.sv =====
package bcd_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;

    localparam logic [7:0] MAGIC_H     = 8'h48;
    localparam logic [7:0] MAGIC_F     = 8'h46;
    localparam logic [7:0] FOOTER_BYTE = 8'h58;

    localparam logic [7:0] VERSION_RESET = 8'd1;

    typedef enum logic [2:0] {
        PH_HDR      = 3'd0,
        PH_HDR_BAD  = 3'd1,
        PH_TSIZE    = 3'd2,
        PH_MSIZE    = 3'd3,
        PH_CONTENT  = 3'd4,
        PH_FOOT     = 3'd5,
        PH_FOOT_BAD = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_CONTENT = 3'd1,
        ST_DONE    = 3'd2,
        ST_EOF     = 3'd3,
        ST_HEADER  = 3'd4,
        ST_VERSION = 3'd5,
        ST_FOOTER  = 3'd6
    } t_status;

    // classified input item
    typedef struct packed {
        logic [7:0] data;
        logic       stream_end;
        logic       is_h;
        logic       is_f;
        logic       is_x;
    } t_item;

endpackage

// ===== src/bcd_front.sv =====
module bcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_stream_end,
    output logic          o_q_valid,
    output bcd_pkg::t_item o_q_item,
    input  logic          i_pop
);
    import bcd_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic [Q_AW:0]     n_count;
    logic              push;
    logic              pop;
    t_item             item;

    always_comb begin
        item.data       = i_data_byte;
        item.stream_end = i_stream_end;
        item.is_h       = (i_data_byte == MAGIC_H);
        item.is_f       = (i_data_byte == MAGIC_F);
        item.is_x       = (i_data_byte == FOOTER_BYTE);
    end

    assign o_in_stall = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_pop && o_q_valid;
    assign o_q_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (Q_AW+1)'(Q_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

// ===== src/bcd_back.sv =====
module bcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_version,
    input  logic           i_q_valid,
    input  bcd_pkg::t_item i_q_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [2:0]     o_status,
    output logic [7:0]     o_tree_bits,
    output logic [3:0]     o_tree_bit_count,
    output logic [7:0]     o_message_bits,
    output logic [3:0]     o_message_bit_count,
    output logic [15:0]    o_tree_size_out,
    output logic [31:0]    o_message_size_out
);
    import bcd_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [1:0]  r_pos,       n_pos;
    logic [15:0] r_tree_len,  n_tree_len;
    logic [31:0] r_msg_len,   n_msg_len;
    logic [15:0] r_tree_left, n_tree_left;
    logic [31:0] r_msg_left,  n_msg_left;

    logic        r_out_valid;
    t_status     r_status,    n_status;
    logic [7:0]  r_tbits,     n_tbits;
    logic [3:0]  r_tcnt,      n_tcnt;
    logic [7:0]  r_mbits,     n_mbits;
    logic [3:0]  r_mcnt,      n_mcnt;

    logic [3:0]  c_tcnt;
    logic [3:0]  c_mroom;
    logic [3:0]  c_mcnt;
    logic [7:0]  c_shifted;
    logic [15:0] c_tree_left;
    logic [31:0] c_msg_left;
    logic        magic_hit;
    t_item       it;

    assign it    = i_q_item;
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // content split
    always_comb begin
        c_tcnt      = (r_tree_left < 16'd8) ? r_tree_left[3:0] : 4'd8;
        c_mroom     = 4'd8 - c_tcnt;
        c_mcnt      = (r_msg_left < {28'd0, c_mroom}) ? r_msg_left[3:0] : c_mroom;
        c_shifted   = it.data << c_tcnt;
        c_tree_left = r_tree_left - {12'd0, c_tcnt};
        c_msg_left  = r_msg_left - {28'd0, c_mcnt};
        magic_hit   = (r_pos == 2'd0) ? it.is_h : it.is_f;
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_tree_len  = r_tree_len;
        n_msg_len   = r_msg_len;
        n_tree_left = r_tree_left;
        n_msg_left  = r_msg_left;
        n_status    = ST_BUSY;
        n_tbits     = '0;
        n_tcnt      = '0;
        n_mbits     = '0;
        n_mcnt      = '0;
        if (it.stream_end) begin
            n_status = ST_EOF;
            n_phase  = PH_HDR;
            n_pos    = '0;
        end else begin
            unique case (r_phase)
                PH_HDR, PH_HDR_BAD: begin
                    if (r_pos != 2'd3) begin
                        if (!magic_hit) begin
                            n_phase = PH_HDR_BAD;
                        end
                        n_pos = r_pos + 2'd1;
                    end else if (r_phase == PH_HDR_BAD) begin
                        n_status = ST_HEADER;
                        n_phase  = PH_HDR;
                        n_pos    = '0;
                    end else if (it.data != i_version) begin
                        n_status = ST_VERSION;
                        n_phase  = PH_HDR;
                        n_pos    = '0;
                    end else begin
                        n_tree_len = '0;
                        n_msg_len  = '0;
                        n_phase    = PH_TSIZE;
                        n_pos      = '0;
                    end
                end
                PH_TSIZE: begin
                    if (r_pos[0]) begin
                        n_tree_len[15:8] = r_tree_len[15:8] | it.data;
                        n_phase          = PH_MSIZE;
                        n_pos            = '0;
                    end else begin
                        n_tree_len[7:0] = r_tree_len[7:0] | it.data;
                        n_pos           = 2'd1;
                    end
                end
                PH_MSIZE: begin
                    unique case (r_pos)
                        2'd0: n_msg_len[7:0]   = r_msg_len[7:0]   | it.data;
                        2'd1: n_msg_len[15:8]  = r_msg_len[15:8]  | it.data;
                        2'd2: n_msg_len[23:16] = r_msg_len[23:16] | it.data;
                        default: n_msg_len[31:24] = r_msg_len[31:24] | it.data;
                    endcase
                    if (r_pos == 2'd3) begin
                        n_tree_left = r_tree_len;
                        n_msg_left  = n_msg_len;
                        n_pos       = '0;
                        n_phase     = (r_tree_len == '0 && n_msg_len == '0)
                                      ? PH_FOOT : PH_CONTENT;
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
                PH_CONTENT: begin
                    n_status    = ST_CONTENT;
                    n_tcnt      = c_tcnt;
                    n_mcnt      = c_mcnt;
                    n_tbits     = it.data & (8'hFF << (4'd8 - c_tcnt));
                    n_mbits     = c_shifted & (8'hFF << (4'd8 - c_mcnt));
                    n_tree_left = c_tree_left;
                    n_msg_left  = c_msg_left;
                    if (c_tree_left == '0 && c_msg_left == '0) begin
                        n_phase = PH_FOOT;
                        n_pos   = '0;
                    end
                end
                PH_FOOT, PH_FOOT_BAD: begin
                    if (r_pos == 2'd0) begin
                        if (!it.is_x) begin
                            n_phase = PH_FOOT_BAD;
                        end
                        n_pos = 2'd1;
                    end else begin
                        n_status = (r_phase == PH_FOOT_BAD || !it.is_x)
                                   ? ST_FOOTER : ST_DONE;
                        n_phase  = PH_HDR;
                        n_pos    = '0;
                    end
                end
                default: begin
                    n_phase = PH_HDR;
                    n_pos   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_pos       <= '0;
            r_tree_len  <= '0;
            r_msg_len   <= '0;
            r_tree_left <= '0;
            r_msg_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_tree_len  <= n_tree_len;
                r_msg_len   <= n_msg_len;
                r_tree_left <= n_tree_left;
                r_msg_left  <= n_msg_left;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_tbits  <= n_tbits;
            r_tcnt   <= n_tcnt;
            r_mbits  <= n_mbits;
            r_mcnt   <= n_mcnt;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_tree_bits         = r_tbits;
    assign o_tree_bit_count    = r_tcnt;
    assign o_message_bits      = r_mbits;
    assign o_message_bit_count = r_mcnt;
    assign o_tree_size_out     = r_tree_len;
    assign o_message_size_out  = r_msg_len;

    a_content_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CONTENT |-> (r_tree_left != '0 || r_msg_left != '0))
        else $error("content phase with nothing left");

    a_split_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_CONTENT) |->
            ({1'b0, r_tcnt} + {1'b0, r_mcnt}) <= 5'd8)
        else $error("split exceeds one byte");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_CONTENT) |->
            (r_tcnt == '0 && r_mcnt == '0 && r_tbits == '0 && r_mbits == '0))
        else $error("bit fields set on non-content item");

    a_tree_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_CONTENT && r_mcnt != '0 && r_tcnt != '0)
            |-> (r_tcnt + r_mcnt) <= 4'd8)
        else $error("tree and message split overlap");

endmodule

// ===== src/bit_container_deframer.sv =====
// channel | direction | handshake               | payload
// in      | input     | i_in_valid / o_in_stall | i_data_byte, i_stream_end
// out     | output    | o_out_valid / i_out_stall | o_status, o_tree_bits,
//         |           |                         | o_tree_bit_count, o_message_bits,
//         |           |                         | o_message_bit_count, o_tree_size_out,
//         |           |                         | o_message_size_out
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (expected version)
//
// One item per cycle sustained while the output is not stalled; each accepted item passes
// through the two-entry input queue and then the output register.
// The per-byte parser state update is the registered loop that sets this rate.
// Reset is synchronous, active low; it empties the queue and sets the version to 1.
// A stalled output holds its item; the queue keeps taking input until both entries are full.
module bit_container_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_tree_bits,
    output logic [3:0]  o_tree_bit_count,
    output logic [7:0]  o_message_bits,
    output logic [3:0]  o_message_bit_count,
    output logic [15:0] o_tree_size_out,
    output logic [31:0] o_message_size_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import bcd_pkg::*;

    logic [7:0] r_version;
    logic       q_valid;
    t_item      q_item;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_version <= i_cfg_data;
        end
    end

    bcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_pop        (pop)
    );

    bcd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_version           (r_version),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_tree_bits         (o_tree_bits),
        .o_tree_bit_count    (o_tree_bit_count),
        .o_message_bits      (o_message_bits),
        .o_message_bit_count (o_message_bit_count),
        .o_tree_size_out     (o_tree_size_out),
        .o_message_size_out  (o_message_size_out)
    );

endmodule

// ===== test/bit_container_deframer_check.sv =====
module bit_container_deframer_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_tree_bits,
    input  logic [3:0]  i_tree_bit_count,
    input  logic [7:0]  i_message_bits,
    input  logic [3:0]  i_message_bit_count,
    input  logic [15:0] i_tree_size_out,
    input  logic [31:0] i_message_size_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bcd_pkg::*;

    typedef struct {
        t_status     status;
        logic [7:0]  tree_bits;
        logic [3:0]  tree_cnt;
        logic [7:0]  msg_bits;
        logic [3:0]  msg_cnt;
        logic [15:0] tree_total;
        logic [31:0] msg_size;
    } t_byte_split;

    t_byte_split split_q[$];

    // shadow of the parser
    t_phase      ph;
    logic [1:0]  fpos;
    logic [15:0] tree_len;
    logic [31:0] msg_len;
    logic [15:0] tree_left;
    logic [31:0] msg_left;
    logic [7:0]  want_version;

    int mismatches;
    int results_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin, output t_byte_split r);
        logic [3:0] tcnt;
        logic [3:0] mcnt;
        logic [7:0] shifted;
        r = '{status: ST_BUSY, default: '0};
        if (fin) begin
            r.status = ST_EOF;
            ph = PH_HDR;
            fpos = 0;
        end else begin
            case (ph)
                PH_HDR, PH_HDR_BAD: begin
                    if (fpos < 2'd3) begin
                        if (b != ((fpos == 0) ? MAGIC_H : MAGIC_F))
                            ph = PH_HDR_BAD;
                        fpos = fpos + 1'b1;
                    end else if (ph == PH_HDR_BAD) begin
                        r.status = ST_HEADER;
                        ph = PH_HDR;
                        fpos = 0;
                    end else if (b != want_version) begin
                        r.status = ST_VERSION;
                        ph = PH_HDR;
                        fpos = 0;
                    end else begin
                        tree_len = 0;
                        msg_len = 0;
                        ph = PH_TSIZE;
                        fpos = 0;
                    end
                end
                PH_TSIZE: begin
                    tree_len = tree_len | (16'(b) << (fpos[0] ? 8 : 0));
                    if (fpos >= 2'd1) begin
                        ph = PH_MSIZE;
                        fpos = 0;
                    end else begin
                        fpos = 2'd1;
                    end
                end
                PH_MSIZE: begin
                    msg_len = msg_len | (32'(b) << (8 * fpos));
                    if (fpos == 2'd3) begin
                        tree_left = tree_len;
                        msg_left = msg_len;
                        fpos = 0;
                        ph = (tree_len == 0 && msg_len == 0) ? PH_FOOT : PH_CONTENT;
                    end else begin
                        fpos = fpos + 1'b1;
                    end
                end
                PH_CONTENT: begin
                    r.status = ST_CONTENT;
                    tcnt = (tree_left < 16'd8) ? tree_left[3:0] : 4'd8;
                    mcnt = 4'd8 - tcnt;
                    if (msg_left < 32'(mcnt))
                        mcnt = msg_left[3:0];
                    shifted = b << tcnt;
                    r.tree_bits = b & (8'hFF << (4'd8 - tcnt));
                    r.msg_bits = shifted & (8'hFF << (4'd8 - mcnt));
                    r.tree_cnt = tcnt;
                    r.msg_cnt = mcnt;
                    tree_left = tree_left - 16'(tcnt);
                    msg_left = msg_left - 32'(mcnt);
                    if (tree_left == 0 && msg_left == 0) begin
                        ph = PH_FOOT;
                        fpos = 0;
                    end
                end
                PH_FOOT, PH_FOOT_BAD: begin
                    if (fpos == 0) begin
                        if (b != FOOTER_BYTE)
                            ph = PH_FOOT_BAD;
                        fpos = 2'd1;
                    end else begin
                        r.status = (ph == PH_FOOT_BAD || b != FOOTER_BYTE) ? ST_FOOTER : ST_DONE;
                        ph = PH_HDR;
                        fpos = 0;
                    end
                end
                default: begin
                    ph = PH_HDR;
                    fpos = 0;
                end
            endcase
        end
        r.tree_total = tree_len;
        r.msg_size = msg_len;
    endtask

    always @(posedge i_clk) begin : watch
        t_byte_split want;
        t_byte_split seen;
        if (!i_rst_n) begin
            ph = PH_HDR;
            fpos = 0;
            tree_len = 0;
            msg_len = 0;
            tree_left = 0;
            msg_left = 0;
            want_version = VERSION_RESET;
            split_q.delete();
            mismatches = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                want_version = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                seen.status = t_status'(i_status);
                seen.tree_bits = i_tree_bits;
                seen.tree_cnt = i_tree_bit_count;
                seen.msg_bits = i_message_bits;
                seen.msg_cnt = i_message_bit_count;
                seen.tree_total = i_tree_size_out;
                seen.msg_size = i_message_size_out;
                if (split_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, status %0d", i_status));
                end else begin
                    want = split_q.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  seen.status, want.status));
                    if (seen.tree_bits !== want.tree_bits)
                        report_mismatch($sformatf("tree_bits %h, expected %h",
                                                  seen.tree_bits, want.tree_bits));
                    if (seen.tree_cnt !== want.tree_cnt)
                        report_mismatch($sformatf("tree_bit_count %0d, expected %0d",
                                                  seen.tree_cnt, want.tree_cnt));
                    if (seen.msg_bits !== want.msg_bits)
                        report_mismatch($sformatf("message_bits %h, expected %h",
                                                  seen.msg_bits, want.msg_bits));
                    if (seen.msg_cnt !== want.msg_cnt)
                        report_mismatch($sformatf("message_bit_count %0d, expected %0d",
                                                  seen.msg_cnt, want.msg_cnt));
                    if (seen.tree_total !== want.tree_total)
                        report_mismatch($sformatf("tree_size_out %h, expected %h",
                                                  seen.tree_total, want.tree_total));
                    if (seen.msg_size !== want.msg_size)
                        report_mismatch($sformatf("message_size_out %h, expected %h",
                                                  seen.msg_size, want.msg_size));
                end
                results_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_data_byte, i_stream_end, want);
                split_q.push_back(want);
            end
        end
        o_mismatches <= mismatches;
        o_pending <= split_q.size();
    end

endmodule

// ===== test/bit_container_deframer_test.sv =====
module bit_container_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bcd_pkg::*;

    localparam int ITEM_TARGET    = 850;
    localparam int PHASE_ITEMS    = 140;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_stream_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_tree_bits;
    logic [3:0]  o_tree_bit_count;
    logic [7:0]  o_message_bits;
    logic [3:0]  o_message_bit_count;
    logic [15:0] o_tree_size_out;
    logic [31:0] o_message_size_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int mismatches;
    int pending;
    int quiet_cycles;
    int items_sent;
    int containers;
    int clean_containers;
    int settings;
    bit steady;
    logic [7:0] cur_version;
    logic [8:0] frame_q[$];

    bit_container_deframer i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_stream_end        (i_stream_end),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_tree_bits         (o_tree_bits),
        .o_tree_bit_count    (o_tree_bit_count),
        .o_message_bits      (o_message_bits),
        .o_message_bit_count (o_message_bit_count),
        .o_tree_size_out     (o_tree_size_out),
        .o_message_size_out  (o_message_size_out),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    bit_container_deframer_check u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_stream_end        (i_stream_end),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_status            (o_status),
        .i_tree_bits         (o_tree_bits),
        .i_tree_bit_count    (o_tree_bit_count),
        .i_message_bits      (o_message_bits),
        .i_message_bit_count (o_message_bit_count),
        .i_tree_size_out     (o_tree_size_out),
        .i_message_size_out  (o_message_size_out),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_mismatches        (mismatches),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_stream_end <= fin;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[k])
            push_byte(frame_q[k][7:0], frame_q[k][8]);
    endtask

    task automatic build_container(input logic [7:0] ver);
        logic [15:0] tsz;
        logic [31:0] msz;
        longint unsigned nbytes;
        int unsigned pick;
        int unsigned flaw;
        int unsigned k;
        int unsigned cut;
        logic [7:0] b;
        bit huge;
        frame_q.delete();
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            tsz = 0;
            msz = 0;
        end else if (pick < 16) begin
            tsz = 16'($urandom_range(0, 24));
            msz = $urandom_range(0, 48);
        end else if (pick < 19) begin
            tsz = 16'($urandom_range(0, 400));
            msz = $urandom_range(0, 400);
        end else if ($urandom_range(0, 3) == 0) begin
            tsz = 16'hFFFF;
            msz = 32'hFFFF_FFFF;
        end else begin
            tsz = 16'($urandom());
            msz = $urandom();
        end
        nbytes = (longint'(tsz) + longint'(msz) + 7) / 8;
        huge = (nbytes > 120);
        frame_q.push_back({1'b0, MAGIC_H});
        frame_q.push_back({1'b0, MAGIC_F});
        frame_q.push_back({1'b0, MAGIC_F});
        frame_q.push_back({1'b0, ver});
        frame_q.push_back({1'b0, tsz[7:0]});
        frame_q.push_back({1'b0, tsz[15:8]});
        for (int i = 0; i < 4; i++)
            frame_q.push_back({1'b0, msz[8*i +: 8]});
        if (huge) begin
            // too long to finish: cut it off inside the content
            repeat ($urandom_range(0, 30))
                frame_q.push_back({1'b0, 8'($urandom())});
            frame_q.push_back({1'b1, 8'($urandom())});
            containers++;
            return;
        end
        repeat (nbytes)
            frame_q.push_back({1'b0, 8'($urandom())});
        frame_q.push_back({1'b0, FOOTER_BYTE});
        frame_q.push_back({1'b0, FOOTER_BYTE});
        flaw = $urandom_range(0, 99);
        if (flaw < 70) begin
            clean_containers++;
        end else if (flaw < 76) begin
            k = $urandom_range(0, 2);
            do b = 8'($urandom()); while (b == ((k == 0) ? MAGIC_H : MAGIC_F));
            frame_q[k] = {1'b0, b};
        end else if (flaw < 82) begin
            frame_q[3] = {1'b0, ver ^ 8'($urandom_range(1, 255))};
        end else if (flaw < 90) begin
            k = frame_q.size() - 1 - $urandom_range(0, 1);
            do b = 8'($urandom()); while (b == FOOTER_BYTE);
            frame_q[k] = {1'b0, b};
        end else begin
            cut = $urandom_range(0, frame_q.size() - 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
            frame_q.push_back({1'b1, 8'($urandom())});
        end
        containers++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_version(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_version = v;
    endtask

    initial begin
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int n;
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_start;
        logic [7:0] v;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= '0;
        i_stream_end <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        quiet_cycles = 0;
        items_sent = 0;
        containers = 0;
        clean_containers = 0;
        settings = 0;
        steady = 1'b0;
        cur_version = VERSION_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // end marker before any header
        push_byte(8'hFF, 1'b1);
        // bad magic wins over a good version
        push_byte(8'h00, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(VERSION_RESET, 1'b0);
        // wrong version
        push_byte(MAGIC_H, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(8'hFF, 1'b0);
        // empty content: footer right after the sizes
        push_byte(MAGIC_H, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(MAGIC_F, 1'b0);
        push_byte(VERSION_RESET, 1'b0);
        repeat (6) push_byte(8'h00, 1'b0);
        push_byte(FOOTER_BYTE, 1'b0);
        push_byte(FOOTER_BYTE, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if (settings > 0) begin
                case (settings)
                    1: v = 8'h00;
                    2: v = 8'hFF;
                    default: v = 8'($urandom());
                endcase
                drain();
                write_version(v);
            end
            settings++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
                steady = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4))
                        push_byte(8'($urandom()), $urandom_range(0, 15) == 0);
                build_container(cur_version);
                send_frame();
            end
        end
        drain();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d items in %0d containers (%0d well formed) over %0d version settings",
                 items_sent, containers, clean_containers, settings);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
